/* hw/rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam int unsigned PhaseW    = 5;
   localparam int unsigned TickW     = 16;
   localparam int unsigned ByteW     = 8;
   localparam int unsigned OpW       = 3;
   localparam int unsigned CsrAddrW  = 3;
   localparam int unsigned CsrDataW  = 32;

   localparam logic [OpW-1:0] OP_IDLE  = 3'd0;
   localparam logic [OpW-1:0] OP_START = 3'd1;
   localparam logic [OpW-1:0] OP_STOP  = 3'd2;
   localparam logic [OpW-1:0] OP_WRITE = 3'd3;
   localparam logic [OpW-1:0] OP_READ  = 3'd4;
   localparam logic [OpW-1:0] OP_SACK  = 3'd5;
   localparam logic [OpW-1:0] OP_RACK  = 3'd6;

   localparam logic [PhaseW-1:0] PH_FINAL_STOP  = 5'd3;
   localparam logic [PhaseW-1:0] PH_FINAL_WRITE = 5'd17;
   localparam logic [PhaseW-1:0] PH_FINAL_READ  = 5'd16;
   localparam logic [PhaseW-1:0] PH_FINAL_SHORT = 5'd2;
   localparam logic [PhaseW-1:0] PH_ONE         = 5'd1;
   localparam logic [PhaseW-1:0] PH_TWO         = 5'd2;
   localparam logic [PhaseW-1:0] PH_BITS_END    = 5'd16;

   localparam logic [TickW-1:0] HALF_PERIOD_RESET = 16'd4;

   localparam logic [CsrAddrW-1:0] REG_HALF_PERIOD = 3'd0;

   typedef struct packed {
      logic [OpW-1:0]   op;
      logic [ByteW-1:0] data_byte;
      logic             ack_bit;
      logic             sda_in;
   } req_beat_type;

   typedef struct packed {
      logic             scl_level;
      logic             sda_level;
      logic             busy_res;
      logic             done_res;
      logic [ByteW-1:0] read_byte;
      logic             ack_seen;
      logic             cmd_rejected;
   } rsp_beat_type;

   function automatic logic [PhaseW-1:0] final_phase(input logic [OpW-1:0] cmd);
      logic [PhaseW-1:0] fp;
      case (cmd)
         OP_STOP:  fp = PH_FINAL_STOP;
         OP_WRITE: fp = PH_FINAL_WRITE;
         OP_READ:  fp = PH_FINAL_READ;
         default:  fp = PH_FINAL_SHORT;
      endcase
      return fp;
   endfunction

endpackage

/* hw/rtl/i2cm_req_if.sv */
`timescale 1ns / 1ps

interface i2cm_req_if import i2cm_pkg::*;;
   logic             valid;
   logic             ready;
   logic [OpW-1:0]   op;
   logic [ByteW-1:0] data_byte;
   logic             ack_bit;
   logic             sda_in;

   modport source (output valid, op, data_byte, ack_bit, sda_in, input ready);
   modport sink (input valid, op, data_byte, ack_bit, sda_in, output ready);
endinterface

/* hw/rtl/i2cm_rsp_if.sv */
`timescale 1ns / 1ps

interface i2cm_rsp_if import i2cm_pkg::*;;
   logic             valid;
   logic             ready;
   logic             scl_level;
   logic             sda_level;
   logic             busy_res;
   logic             done_res;
   logic [ByteW-1:0] read_byte;
   logic             ack_seen;
   logic             cmd_rejected;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                   ack_seen, cmd_rejected, input ready);
   modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                 ack_seen, cmd_rejected, output ready);
endinterface

/* hw/rtl/i2cm_csr.sv */
`timescale 1ns / 1ps

module i2cm_csr import i2cm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready,
   output logic [TickW-1:0]    half_period
);

   logic [TickW-1:0] half_period_ff;
   logic [TickW-1:0] half_period_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[CsrAddrW-1] == REG_HALF_PERIOD[2]);

   always_comb begin
      half_period_in = half_period_ff;
      if (wr_hit) begin
         half_period_in = pwdata[TickW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else begin
         half_period_ff <= half_period_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CsrAddrW-1] == REG_HALF_PERIOD[2]) begin
         prdata = {{(CsrDataW-TickW){1'b0}}, half_period_ff};
      end
   end

   assign half_period = half_period_ff;

endmodule

/* hw/rtl/i2cm_seq.sv */
`timescale 1ns / 1ps

module i2cm_seq import i2cm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  req_beat_type     req_beat,
   input  logic [TickW-1:0] half_period,
   output rsp_beat_type     rsp_beat
);

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [TickW-1:0]  tick_count_ff, tick_count_in;
   logic [ByteW-1:0]  shift_ff, shift_in;
   logic [OpW-1:0]    active_cmd_ff, active_cmd_in;
   logic              scl_drv_ff, scl_drv_in;
   logic              sda_drv_ff, sda_drv_in;
   logic              busy_ff, busy_in;
   logic              ack_ff, ack_in;

   logic [TickW-1:0]  hp;
   logic [TickW-1:0]  tick_inc;
   logic [PhaseW-1:0] next_phase;

   assign hp         = (half_period == '0) ? {{(TickW-1){1'b0}}, 1'b1} : half_period;
   assign tick_inc   = tick_count_ff + {{(TickW-1){1'b0}}, 1'b1};
   assign next_phase = phase_ff + PH_ONE;

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      shift_in      = shift_ff;
      active_cmd_in = active_cmd_ff;
      scl_drv_in    = scl_drv_ff;
      sda_drv_in    = sda_drv_ff;
      busy_in       = busy_ff;
      ack_in        = ack_ff;
      rsp_beat      = '0;

      if (busy_ff) begin
         rsp_beat.cmd_rejected = (req_beat.op != OP_IDLE);
         tick_count_in = tick_inc;
         if (tick_inc >= hp) begin
            tick_count_in = '0;
            phase_in      = next_phase;
            if (next_phase >= final_phase(active_cmd_ff)) begin
               scl_drv_in = 1'b0;
               if (active_cmd_ff == OP_WRITE) begin
                  sda_drv_in = 1'b0;
               end
               busy_in           = 1'b0;
               rsp_beat.done_res = 1'b1;
               if (active_cmd_ff == OP_READ) begin
                  rsp_beat.read_byte = shift_ff;
               end
               if (active_cmd_ff == OP_RACK) begin
                  rsp_beat.ack_seen = ack_ff;
               end
               active_cmd_in = OP_IDLE;
               phase_in      = '0;
            end else begin
               case (active_cmd_ff)
                  OP_START: begin
                     if (next_phase == PH_ONE) sda_drv_in = 1'b0;
                  end
                  OP_STOP: begin
                     if (next_phase == PH_ONE) scl_drv_in = 1'b1;
                     else if (next_phase == PH_TWO) sda_drv_in = 1'b1;
                  end
                  OP_WRITE: begin
                     if (next_phase < PH_BITS_END) begin
                        if (!next_phase[0]) begin
                           scl_drv_in = 1'b0;
                           sda_drv_in = shift_ff[ByteW-1];
                           shift_in   = {shift_ff[ByteW-2:0], 1'b0};
                        end else begin
                           scl_drv_in = 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (!next_phase[0]) begin
                        scl_drv_in = 1'b0;
                        sda_drv_in = 1'b1;
                     end else begin
                        scl_drv_in = 1'b1;
                        shift_in   = {shift_ff[ByteW-2:0], req_beat.sda_in};
                     end
                  end
                  OP_SACK: begin
                     if (next_phase == PH_ONE) scl_drv_in = 1'b1;
                  end
                  default: begin
                     if (next_phase == PH_ONE) begin
                        scl_drv_in = 1'b1;
                        ack_in     = req_beat.sda_in;
                     end
                  end
               endcase
            end
         end
      end else if (req_beat.op inside {[OP_START:OP_RACK]}) begin
         active_cmd_in = req_beat.op;
         phase_in      = '0;
         tick_count_in = '0;
         busy_in       = 1'b1;
         case (req_beat.op)
            OP_START: begin
               scl_drv_in = 1'b1;
               sda_drv_in = 1'b1;
            end
            OP_STOP: begin
               scl_drv_in = 1'b0;
               sda_drv_in = 1'b0;
            end
            OP_WRITE: begin
               scl_drv_in = 1'b0;
               sda_drv_in = req_beat.data_byte[ByteW-1];
               shift_in   = {req_beat.data_byte[ByteW-2:0], 1'b0};
            end
            OP_READ: begin
               shift_in   = '0;
               scl_drv_in = 1'b0;
               sda_drv_in = 1'b1;
            end
            OP_SACK: begin
               scl_drv_in = 1'b0;
               sda_drv_in = req_beat.ack_bit;
            end
            default: begin
               scl_drv_in = 1'b0;
               sda_drv_in = 1'b1;
            end
         endcase
      end

      rsp_beat.scl_level = scl_drv_in;
      rsp_beat.sda_level = sda_drv_in;
      rsp_beat.busy_res  = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         tick_count_ff <= '0;
         shift_ff      <= '0;
         active_cmd_ff <= OP_IDLE;
         scl_drv_ff    <= 1'b1;
         sda_drv_ff    <= 1'b1;
         busy_ff       <= 1'b0;
         ack_ff        <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         shift_ff      <= shift_in;
         active_cmd_ff <= active_cmd_in;
         scl_drv_ff    <= scl_drv_in;
         sda_drv_ff    <= sda_drv_in;
         busy_ff       <= busy_in;
         ack_ff        <= ack_in;
      end
   end

endmodule

/* hw/rtl/i2cm_rsp_reg.sv */
`timescale 1ns / 1ps

module i2cm_rsp_reg import i2cm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_beat_type load_beat,
   input  logic         take,
   output logic         can_load,
   output logic         out_valid,
   output rsp_beat_type out_beat
);

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff, beat_in;

   assign can_load = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = load_beat;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

/* hw/rtl/i2c_master_bit_engine.sv */
`timescale 1ns / 1ps
// Channel | Dir | Payload                                              | Beat taken when
// req     | in  | op, data_byte, ack_bit, sda_in                       | valid & ready
// rsp     | out | scl_level, sda_level, busy_res, done_res, read_byte, | valid & ready
//         |     | ack_seen, cmd_rejected                               |
// apb     | in  | half_period_ticks where paddr[2] is 0                | psel&penable&pwrite
//
// One req beat gives one rsp beat the next cycle; one per cycle while rsp takes them.
// The sequencer state advances in the cycle a req beat is taken; the rsp register
// holds the result until taken, and req stays ready while that register drains.
// reset is synchronous: lines released, sequencer idle, half period 4 ticks.
// A stalled rsp side holds req off once the rsp register is full.

module i2c_master_bit_engine import i2cm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   i2cm_req_if.sink            req,
   i2cm_rsp_if.source          rsp,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready
);

   logic             accept;
   logic             can_load;
   logic [TickW-1:0] half_period;
   req_beat_type     req_beat;
   rsp_beat_type     step_beat;
   rsp_beat_type     out_beat;

   assign req_beat.op        = req.op;
   assign req_beat.data_byte = req.data_byte;
   assign req_beat.ack_bit   = req.ack_bit;
   assign req_beat.sda_in    = req.sda_in;

   assign req.ready = can_load;
   assign accept    = req.valid && can_load;

   i2cm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .half_period (half_period)
   );

   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_beat    (req_beat),
      .half_period (half_period),
      .rsp_beat    (step_beat)
   );

   i2cm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_beat (step_beat),
      .take      (rsp.ready),
      .can_load  (can_load),
      .out_valid (rsp.valid),
      .out_beat  (out_beat)
   );

   assign rsp.scl_level    = out_beat.scl_level;
   assign rsp.sda_level    = out_beat.sda_level;
   assign rsp.busy_res     = out_beat.busy_res;
   assign rsp.done_res     = out_beat.done_res;
   assign rsp.read_byte    = out_beat.read_byte;
   assign rsp.ack_seen     = out_beat.ack_seen;
   assign rsp.cmd_rejected = out_beat.cmd_rejected;

endmodule

/* hw/rtl/i2cm_checker.sv */
`timescale 1ns / 1ps

module i2cm_checker import i2cm_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             busy_res,
   input logic             done_res,
   input logic [ByteW-1:0] read_byte,
   input logic             ack_seen,
   input logic             cmd_rejected
);

   // hold valid, done_res and read_byte of a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(done_res) && $stable(read_byte))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(done_res && busy_res))
      else $error("done and busy in the same beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((read_byte != '0) || ack_seen) |-> done_res)
      else $error("read data outside a done beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cmd_rejected && !done_res |-> busy_res)
      else $error("command rejected while idle");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .busy_res     (rsp.busy_res),
   .done_res     (rsp.done_res),
   .read_byte    (rsp.read_byte),
   .ack_seen     (rsp.ack_seen),
   .cmd_rejected (rsp.cmd_rejected)
);
